// ----- sv/ptpr_pkg.sv -----
// ptpr_pkg: shared types and constants of the two-step ptp offset receiver
// used by every module of the block, no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ptpr_pkg;

    localparam int unsigned SEC_W      = 48;
    localparam int unsigned NSEC_W     = 30;
    localparam int unsigned TIME_W     = 64;
    localparam int unsigned HALF_SEC_W = SEC_W / 2;
    localparam int unsigned PROD_W     = HALF_SEC_W + NSEC_W;
    localparam int unsigned SEQ_W      = 16;
    localparam int unsigned DOM_W      = 8;
    localparam int unsigned CID_W      = 64;
    localparam int unsigned MAC_W      = 48;

    localparam logic [NSEC_W-1:0] NS_PER_SECOND = NSEC_W'(1000000000);
    localparam logic [7:0]        EUI_BYTE_FF   = 8'hFF;
    localparam logic [7:0]        EUI_BYTE_FE   = 8'hFE;

    typedef enum logic [2:0] {
        REQ_SYNC      = 3'd0,
        REQ_FOLLOWUP  = 3'd1,
        REQ_DLY_RESP  = 3'd2,
        REQ_TX_STAMP  = 3'd3,
        REQ_OTHER     = 3'd4
    } req_type_t;

    typedef enum logic {
        RES_DELAY_REQ = 1'b0,
        RES_OFFSET    = 1'b1
    } res_kind_t;

    typedef struct packed {
        req_type_t          kind;
        logic [SEQ_W-1:0]   seq;
        logic [CID_W-1:0]   src;
        logic [CID_W-1:0]   requester;
        logic [DOM_W-1:0]   dom;
    } evt_t;

    typedef struct packed {
        res_kind_t          kind;
        logic [SEQ_W-1:0]   seq;
        logic [DOM_W-1:0]   dom;
        logic [CID_W-1:0]   cid;
        logic [TIME_W-1:0]  diff;
    } res_t;

    function automatic logic [CID_W-1:0] eui64_from_mac(input logic [MAC_W-1:0] mac);
        eui64_from_mac = {mac[MAC_W-1:MAC_W/2], EUI_BYTE_FF, EUI_BYTE_FE, mac[MAC_W/2-1:0]};
    endfunction

endpackage

`default_nettype wire

// ----- sv/ptp_two_step_offset_receiver.sv -----
// ptp_two_step_offset_receiver: top level of the two-step e2e ptp offset receiver
// depends on ptpr_pkg, ptpr_stamp_conv, ptpr_core, ptpr_out
//
// channel  direction  handshake            payload
// s_       in         s_valid / s_ready    parsed ptp event item
// m_       out        m_valid / m_ready    delay request or offset delta item
// cfg_     in         cfg_valid / cfg_ready own mac address
//
// one item per cycle sustained while m_ready is high, the result is registered in each stage below
// stages: two for the stamp multiply and sum, one state update, one output register
// m_ready low holds the full stages; s_ready drops only once every stage ahead is full
// items that give no result leave the pipe at the state stage
// reset is synchronous and clears all state and valid flags, mac resets to zero
`timescale 1ns / 1ps
`default_nettype none

module ptp_two_step_offset_receiver (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [ptpr_pkg::MAC_W-1:0]    cfg_own_mac_address,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [2:0]                    s_req_type,
    input  wire logic [ptpr_pkg::SEQ_W-1:0]    s_seq_id,
    input  wire logic [ptpr_pkg::CID_W-1:0]    s_source_clock_id,
    input  wire logic [ptpr_pkg::CID_W-1:0]    s_requester_clock_id,
    input  wire logic [ptpr_pkg::DOM_W-1:0]    s_domain,
    input  wire logic [ptpr_pkg::SEC_W-1:0]    s_msg_seconds,
    input  wire logic [ptpr_pkg::NSEC_W-1:0]   s_msg_nanoseconds,
    input  wire logic [ptpr_pkg::SEC_W-1:0]    s_local_seconds,
    input  wire logic [ptpr_pkg::NSEC_W-1:0]   s_local_nanoseconds,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_result_kind,
    output logic [ptpr_pkg::SEQ_W-1:0]         m_request_seq_id,
    output logic [ptpr_pkg::DOM_W-1:0]         m_request_domain,
    output logic [ptpr_pkg::CID_W-1:0]         m_request_clock_id,
    output logic signed [ptpr_pkg::TIME_W-1:0] m_offset_delta
);

    logic                        v1_reg, v2_reg;
    ptpr_pkg::evt_t              evt1_reg, evt2_reg, evt_in;
    logic                        ready1, ready2, ready3;
    logic                        res_valid, out_ready;
    ptpr_pkg::res_t              res;
    logic [ptpr_pkg::TIME_W-1:0] msg_ns, loc_ns;

    assign cfg_ready = 1'b1;

    assign ready3  = !res_valid || out_ready;
    assign ready2  = !v2_reg || ready3;
    assign ready1  = !v1_reg || ready2;
    assign s_ready = ready1;

    always_comb begin
        evt_in.kind      = ptpr_pkg::req_type_t'(s_req_type);
        evt_in.seq       = s_seq_id;
        evt_in.src       = s_source_clock_id;
        evt_in.requester = s_requester_clock_id;
        evt_in.dom       = s_domain;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (ready1) begin
                v1_reg <= s_valid;
            end
            if (ready2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ready1) begin
            evt1_reg <= evt_in;
        end
        if (ready2) begin
            evt2_reg <= evt1_reg;
        end
    end

    ptpr_stamp_conv u_msg_conv (
        .aclk        (aclk),
        .load_prod   (ready1),
        .load_sum    (ready2),
        .seconds     (s_msg_seconds),
        .nanoseconds (s_msg_nanoseconds),
        .time_ns     (msg_ns)
    );

    ptpr_stamp_conv u_loc_conv (
        .aclk        (aclk),
        .load_prod   (ready1),
        .load_sum    (ready2),
        .seconds     (s_local_seconds),
        .nanoseconds (s_local_nanoseconds),
        .time_ns     (loc_ns)
    );

    ptpr_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_mac   (cfg_own_mac_address),
        .take      (v2_reg && ready3),
        .load      (ready3),
        .evt       (evt2_reg),
        .msg_ns    (msg_ns),
        .loc_ns    (loc_ns),
        .res_valid (res_valid),
        .res       (res)
    );

    ptpr_out u_out (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .res_valid          (res_valid),
        .res                (res),
        .res_ready          (out_ready),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_result_kind      (m_result_kind),
        .m_request_seq_id   (m_request_seq_id),
        .m_request_domain   (m_request_domain),
        .m_request_clock_id (m_request_clock_id),
        .m_offset_delta     (m_offset_delta)
    );

endmodule

`default_nettype wire

// ----- sv/ptpr_stamp_conv.sv -----
// ptpr_stamp_conv: two-stage conversion of a seconds/nanoseconds stamp to ns mod 2^64
// depends on ptpr_pkg
`timescale 1ns / 1ps
`default_nettype none

module ptpr_stamp_conv (
    input  wire logic                             aclk,
    input  wire logic                             load_prod,
    input  wire logic                             load_sum,
    input  wire logic [ptpr_pkg::SEC_W-1:0]       seconds,
    input  wire logic [ptpr_pkg::NSEC_W-1:0]      nanoseconds,
    output logic      [ptpr_pkg::TIME_W-1:0]      time_ns
);

    logic [ptpr_pkg::PROD_W-1:0] prod_lo_reg, prod_lo_next;
    logic [ptpr_pkg::PROD_W-1:0] prod_hi_reg, prod_hi_next;
    logic [ptpr_pkg::NSEC_W-1:0] nsec_reg;
    logic [ptpr_pkg::TIME_W-1:0] time_reg, time_next;

    // split seconds in two halves, one constant multiply each
    always_comb begin
        prod_lo_next = ptpr_pkg::PROD_W'(seconds[ptpr_pkg::HALF_SEC_W-1:0])
                       * ptpr_pkg::PROD_W'(ptpr_pkg::NS_PER_SECOND);
        prod_hi_next = ptpr_pkg::PROD_W'(seconds[ptpr_pkg::SEC_W-1:ptpr_pkg::HALF_SEC_W])
                       * ptpr_pkg::PROD_W'(ptpr_pkg::NS_PER_SECOND);
    end

    always_comb begin
        time_next = ptpr_pkg::TIME_W'(prod_lo_reg)
                  + {prod_hi_reg[ptpr_pkg::TIME_W-ptpr_pkg::HALF_SEC_W-1:0],
                     {ptpr_pkg::HALF_SEC_W{1'b0}}}
                  + ptpr_pkg::TIME_W'(nsec_reg);
    end

    always_ff @(posedge aclk) begin
        if (load_prod) begin
            prod_lo_reg <= prod_lo_next;
            prod_hi_reg <= prod_hi_next;
            nsec_reg    <= nanoseconds;
        end
        if (load_sum) begin
            time_reg <= time_next;
        end
    end

    assign time_ns = time_reg;

endmodule

`default_nettype wire

// ----- sv/ptpr_core.sv -----
// ptpr_core: receiver state, sequence and id matching, result register
// depends on ptpr_pkg
`timescale 1ns / 1ps
`default_nettype none

module ptpr_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_write,
    input  wire logic [ptpr_pkg::MAC_W-1:0]    cfg_mac,
    input  wire logic                          take,
    input  wire logic                          load,
    input  wire ptpr_pkg::evt_t                evt,
    input  wire logic [ptpr_pkg::TIME_W-1:0]   msg_ns,
    input  wire logic [ptpr_pkg::TIME_W-1:0]   loc_ns,
    output logic                               res_valid,
    output ptpr_pkg::res_t                     res
);

    logic [ptpr_pkg::MAC_W-1:0]  mac_reg;
    logic [ptpr_pkg::CID_W-1:0]  master_id_reg, master_id_next;
    logic                        latched_reg, latched_next;
    logic [ptpr_pkg::SEQ_W-1:0]  sync_seq_reg, sync_seq_next;
    logic [ptpr_pkg::SEQ_W-1:0]  fu_seq_reg, fu_seq_next;
    logic [ptpr_pkg::CID_W-1:0]  own_id_reg, own_id_next;
    logic [ptpr_pkg::TIME_W-1:0] t1_reg, t1_next;
    logic [ptpr_pkg::TIME_W-1:0] t2_reg, t2_next;
    logic [ptpr_pkg::TIME_W-1:0] t3_reg, t3_next;
    logic [ptpr_pkg::TIME_W-1:0] base_reg, base_next;
    logic                        valid_reg, valid_next;
    ptpr_pkg::res_t              res_reg, res_next;
    logic [ptpr_pkg::CID_W-1:0]  master_eff;
    logic [ptpr_pkg::CID_W-1:0]  eui;

    assign eui = ptpr_pkg::eui64_from_mac(mac_reg);

    always_comb begin
        master_id_next = master_id_reg;
        latched_next   = latched_reg;
        sync_seq_next  = sync_seq_reg;
        fu_seq_next    = fu_seq_reg;
        own_id_next    = own_id_reg;
        t1_next        = t1_reg;
        t2_next        = t2_reg;
        t3_next        = t3_reg;
        base_next      = base_reg;
        valid_next     = 1'b0;
        res_next       = '0;
        master_eff     = latched_reg ? master_id_reg : evt.src;
        if (take) begin
            case (evt.kind)
                ptpr_pkg::REQ_SYNC: begin
                    sync_seq_next = evt.seq;
                    if (!latched_reg) begin
                        master_id_next = evt.src;
                        latched_next   = 1'b1;
                    end
                    if (evt.src == master_eff) begin
                        t2_next   = loc_ns;
                        base_next = loc_ns - t1_reg;
                    end
                end
                ptpr_pkg::REQ_FOLLOWUP: begin
                    if (evt.src == master_id_reg) begin
                        fu_seq_next = evt.seq;
                        t1_next     = msg_ns;
                        base_next   = t2_reg - msg_ns;
                        if (evt.seq == sync_seq_reg) begin
                            own_id_next   = eui;
                            t3_next       = '0;
                            valid_next    = 1'b1;
                            res_next.kind = ptpr_pkg::RES_DELAY_REQ;
                            res_next.seq  = sync_seq_reg;
                            res_next.dom  = evt.dom;
                            res_next.cid  = eui;
                        end
                    end
                end
                ptpr_pkg::REQ_DLY_RESP: begin
                    if (evt.requester == own_id_reg && evt.seq == fu_seq_reg) begin
                        valid_next    = 1'b1;
                        res_next.kind = ptpr_pkg::RES_OFFSET;
                        res_next.diff = base_reg - (msg_ns - t3_reg);
                    end
                end
                ptpr_pkg::REQ_TX_STAMP: begin
                    t3_next = loc_ns;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mac_reg       <= '0;
            master_id_reg <= '0;
            latched_reg   <= 1'b0;
            sync_seq_reg  <= '0;
            fu_seq_reg    <= '0;
            own_id_reg    <= '0;
            t1_reg        <= '0;
            t2_reg        <= '0;
            t3_reg        <= '0;
            base_reg      <= '0;
            valid_reg     <= 1'b0;
        end else begin
            if (cfg_write) begin
                mac_reg <= cfg_mac;
            end
            master_id_reg <= master_id_next;
            latched_reg   <= latched_next;
            sync_seq_reg  <= sync_seq_next;
            fu_seq_reg    <= fu_seq_next;
            own_id_reg    <= own_id_next;
            t1_reg        <= t1_next;
            t2_reg        <= t2_next;
            t3_reg        <= t3_next;
            base_reg      <= base_next;
            if (load) begin
                valid_reg <= valid_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res_next;
        end
    end

    assign res_valid = valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

// ----- sv/ptpr_out.sv -----
// ptpr_out: output register, halves and negates the time difference
// depends on ptpr_pkg
`timescale 1ns / 1ps
`default_nettype none

module ptpr_out (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          res_valid,
    input  wire ptpr_pkg::res_t                res,
    output logic                               res_ready,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_result_kind,
    output logic [ptpr_pkg::SEQ_W-1:0]         m_request_seq_id,
    output logic [ptpr_pkg::DOM_W-1:0]         m_request_domain,
    output logic [ptpr_pkg::CID_W-1:0]         m_request_clock_id,
    output logic signed [ptpr_pkg::TIME_W-1:0] m_offset_delta
);

    logic                        valid_reg;
    ptpr_pkg::res_t              res_reg;
    logic [ptpr_pkg::TIME_W-1:0] delta_reg, delta_next;
    logic [ptpr_pkg::TIME_W-1:0] neg_diff;
    logic [ptpr_pkg::TIME_W-1:0] half_diff;

    assign res_ready = !valid_reg || m_ready;

    // -(diff)/2 truncated toward zero, negation wraps
    always_comb begin
        neg_diff  = '0 - res.diff;
        half_diff = {1'b0, res.diff[ptpr_pkg::TIME_W-1:1]};
        if (neg_diff[ptpr_pkg::TIME_W-1]) begin
            delta_next = '0 - half_diff;
        end else begin
            delta_next = {1'b0, neg_diff[ptpr_pkg::TIME_W-1:1]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (res_ready) begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready) begin
            res_reg   <= res;
            delta_reg <= delta_next;
        end
    end

    assign m_valid            = valid_reg;
    assign m_result_kind      = res_reg.kind;
    assign m_request_seq_id   = res_reg.seq;
    assign m_request_domain   = res_reg.dom;
    assign m_request_clock_id = res_reg.cid;
    assign m_offset_delta     = $signed(delta_reg);

endmodule

`default_nettype wire
